// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of the layout resolver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante; silent while reset is low.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante; silent while reset is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/arlr_pkg.sv -----
// Package of types, constants and helpers for the layout resolver.
`timescale 1ns / 1ps

package arlr_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = 6;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int COORD_W      = 16;
    localparam int DIM_W        = 15;
    localparam int FILL_W       = 16;
    localparam int CFILL_W      = 15;
    localparam int FLAGS_W      = 10;
    localparam int STATUS_W     = 2;
    localparam int WIDE_W       = 20;

    localparam logic [CFILL_W-1:0] FILL_ONE = CFILL_W'(16384);
    localparam logic [IDX_W:0]     ELEM_LIMIT = (IDX_W + 1)'(MAX_ELEMENTS);

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ELEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ANCH = 2'd2;

    // Alignment flag positions.
    localparam int FLG_IN_L  = 0;
    localparam int FLG_IN_R  = 1;
    localparam int FLG_IN_T  = 2;
    localparam int FLG_IN_B  = 3;
    localparam int FLG_OUT_L = 4;
    localparam int FLG_OUT_R = 5;
    localparam int FLG_OUT_T = 6;
    localparam int FLG_OUT_B = 7;
    localparam int FLG_HCTR  = 8;
    localparam int FLG_VCTR  = 9;

    // Configuration register indexes.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_W = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_H = 1'd1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DIM_W-1:0] SCREEN_W_RST = DIM_W'(640);
    localparam logic [DIM_W-1:0] SCREEN_H_RST = DIM_W'(480);

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } t_rect;

    typedef struct packed {
        logic [DIM_W-1:0] screen_w;
        logic [DIM_W-1:0] screen_h;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]          element_index;
        logic [IDX_W-1:0]          anchor_index;
        logic signed [COORD_W-1:0] offset_left;
        logic signed [COORD_W-1:0] offset_top;
        logic [DIM_W-1:0]          rect_width;
        logic [DIM_W-1:0]          rect_height;
        logic [FLAGS_W-1:0]        align_flags;
        logic                      is_texture;
        logic signed [FILL_W-1:0]  fill_width;
        logic signed [FILL_W-1:0]  fill_height;
    } t_job;

    typedef struct packed {
        t_rect               rect;
        logic [CFILL_W-1:0]  clamped_fill_width;
        logic [CFILL_W-1:0]  clamped_fill_height;
        logic [STATUS_W-1:0] status;
    } t_result;

    // Saturate a wide signed sum to a 16-bit edge.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic all_same;
        all_same = (&v[WIDE_W-1:COORD_W-1]) | ~(|v[WIDE_W-1:COORD_W-1]);
        if (all_same) begin
            sat_coord = v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // Clamp a Q2.14 fill to the range zero to one.
    function automatic logic [CFILL_W-1:0] clamp_fill(input logic signed [FILL_W-1:0] f);
        if (f[FILL_W-1]) begin
            clamp_fill = '0;
        end else if (f[CFILL_W-1:0] > FILL_ONE) begin
            clamp_fill = FILL_ONE;
        end else begin
            clamp_fill = f[CFILL_W-1:0];
        end
    endfunction

endpackage

// ----- design/arlr_in_if.sv -----
// Input word channel of the layout resolver.
`timescale 1ns / 1ps

interface arlr_in_if;
    logic                               valid;
    logic                               ready;
    logic [arlr_pkg::IDX_W-1:0]         element_index;
    logic [arlr_pkg::IDX_W-1:0]         anchor_index;
    logic signed [arlr_pkg::COORD_W-1:0] offset_left;
    logic signed [arlr_pkg::COORD_W-1:0] offset_top;
    logic [arlr_pkg::DIM_W-1:0]         rect_width;
    logic [arlr_pkg::DIM_W-1:0]         rect_height;
    logic [arlr_pkg::FLAGS_W-1:0]       align_flags;
    logic                               is_texture;
    logic signed [arlr_pkg::FILL_W-1:0] fill_width;
    logic signed [arlr_pkg::FILL_W-1:0] fill_height;

    modport source (
        output valid, element_index, anchor_index, offset_left, offset_top,
               rect_width, rect_height, align_flags, is_texture, fill_width, fill_height,
        input  ready
    );
    modport sink (
        input  valid, element_index, anchor_index, offset_left, offset_top,
               rect_width, rect_height, align_flags, is_texture, fill_width, fill_height,
        output ready
    );
endinterface

// ----- design/arlr_out_if.sv -----
// Result word channel of the layout resolver.
`timescale 1ns / 1ps

interface arlr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [arlr_pkg::COORD_W-1:0] out_left;
    logic signed [arlr_pkg::COORD_W-1:0] out_top;
    logic signed [arlr_pkg::COORD_W-1:0] out_right;
    logic signed [arlr_pkg::COORD_W-1:0] out_bottom;
    logic [arlr_pkg::CFILL_W-1:0]        clamped_fill_width;
    logic [arlr_pkg::CFILL_W-1:0]        clamped_fill_height;
    logic [arlr_pkg::STATUS_W-1:0]       status;

    modport source (
        output valid, out_left, out_top, out_right, out_bottom,
               clamped_fill_width, clamped_fill_height, status,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_top, out_right, out_bottom,
               clamped_fill_width, clamped_fill_height, status,
        output ready
    );
endinterface

// ----- design/arlr_cfg_regs.sv -----
// APB register block holding the screen size.
`timescale 1ns / 1ps

module arlr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [arlr_pkg::PADDR_W-1:0]   paddr,
    input  logic [arlr_pkg::PDATA_W-1:0]   pwdata,
    output logic [arlr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output arlr_pkg::t_cfg                 o_cfg
);

    logic [arlr_pkg::DIM_W-1:0]     r_screen_w;
    logic [arlr_pkg::DIM_W-1:0]     r_screen_h;
    logic [arlr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[arlr_pkg::PADDR_W-1:arlr_pkg::PADDR_W-arlr_pkg::REG_IDX_W];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= arlr_pkg::SCREEN_W_RST;
            r_screen_h <= arlr_pkg::SCREEN_H_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                arlr_pkg::REG_SCREEN_W: r_screen_w <= pwdata[arlr_pkg::DIM_W-1:0];
                arlr_pkg::REG_SCREEN_H: r_screen_h <= pwdata[arlr_pkg::DIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            arlr_pkg::REG_SCREEN_W: prdata = arlr_pkg::PDATA_W'(r_screen_w);
            arlr_pkg::REG_SCREEN_H: prdata = arlr_pkg::PDATA_W'(r_screen_h);
        endcase
    end

    assign o_cfg.screen_w = r_screen_w;
    assign o_cfg.screen_h = r_screen_h;

endmodule

// ----- design/arlr_rect_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module arlr_rect_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/arlr_place.sv -----
// Placement logic: anchor select, alignment, saturation and fill clamp.
`timescale 1ns / 1ps

module arlr_place (
    input  arlr_pkg::t_job    i_job,
    input  arlr_pkg::t_rect   i_anchor,
    input  arlr_pkg::t_cfg    i_cfg,
    output arlr_pkg::t_result o_res,
    output logic              o_wr_en
);

    localparam int WW = arlr_pkg::WIDE_W;

    arlr_pkg::t_rect        screen;
    arlr_pkg::t_rect        anc;
    logic signed [WW-1:0]   a_l, a_t, a_r, a_b;
    logic signed [WW-1:0]   w_s, h_s;
    logic signed [WW-1:0]   dx, dy, dx_adj, dy_adj;
    logic signed [WW-1:0]   left_w, top_w;
    logic                   bad_elem, bad_anch;
    logic [arlr_pkg::FLAGS_W-1:0] fl;
    logic [arlr_pkg::CFILL_W-1:0] fw, fh;

    assign screen.left   = '0;
    assign screen.top    = '0;
    assign screen.right  = arlr_pkg::COORD_W'(i_cfg.screen_w);
    assign screen.bottom = arlr_pkg::COORD_W'(i_cfg.screen_h);

    // Slot zero always follows the registers, never the table.
    assign anc = (i_job.anchor_index == '0) ? screen : i_anchor;

    assign a_l = WW'(anc.left);
    assign a_t = WW'(anc.top);
    assign a_r = WW'(anc.right);
    assign a_b = WW'(anc.bottom);
    assign w_s = WW'(i_job.rect_width);
    assign h_s = WW'(i_job.rect_height);
    assign fl  = i_job.align_flags;

    // Halve toward zero: bias negative spans by one before the shift.
    assign dx     = a_r - a_l;
    assign dy     = a_b - a_t;
    assign dx_adj = dx + {{(WW-1){1'b0}}, dx[WW-1]};
    assign dy_adj = dy + {{(WW-1){1'b0}}, dy[WW-1]};

    always_comb begin
        left_w = a_l + WW'(i_job.offset_left);
        if (fl[arlr_pkg::FLG_IN_L])  left_w = a_l;
        if (fl[arlr_pkg::FLG_IN_R])  left_w = a_r - w_s;
        if (fl[arlr_pkg::FLG_OUT_L]) left_w = a_l - w_s;
        if (fl[arlr_pkg::FLG_OUT_R]) left_w = a_r;
        if (fl[arlr_pkg::FLG_HCTR])  left_w = a_l + (dx_adj >>> 1) - (w_s >>> 1);
    end

    always_comb begin
        top_w = a_t + WW'(i_job.offset_top);
        if (fl[arlr_pkg::FLG_IN_T])  top_w = a_t;
        if (fl[arlr_pkg::FLG_IN_B])  top_w = a_b - h_s;
        if (fl[arlr_pkg::FLG_OUT_T]) top_w = a_t - h_s;
        if (fl[arlr_pkg::FLG_OUT_B]) top_w = a_b;
        if (fl[arlr_pkg::FLG_VCTR])  top_w = a_t + (dy_adj >>> 1) - (h_s >>> 1);
    end

    assign bad_elem = {1'b0, i_job.element_index} >= arlr_pkg::ELEM_LIMIT;
    assign bad_anch = ({1'b0, i_job.anchor_index} >= arlr_pkg::ELEM_LIMIT) ||
                      ((i_job.element_index != '0) &&
                       (i_job.anchor_index >= i_job.element_index));

    assign fw = i_job.is_texture ? arlr_pkg::clamp_fill(i_job.fill_width)  : '0;
    assign fh = i_job.is_texture ? arlr_pkg::clamp_fill(i_job.fill_height) : '0;

    always_comb begin
        o_res   = '0;
        o_wr_en = 1'b0;
        priority if (bad_elem) begin
            o_res.status = arlr_pkg::ST_BAD_ELEM;
        end else if (bad_anch) begin
            o_res.status = arlr_pkg::ST_BAD_ANCH;
        end else if (i_job.element_index == '0) begin
            o_res.rect                = screen;
            o_res.clamped_fill_width  = fw;
            o_res.clamped_fill_height = fh;
            o_res.status              = arlr_pkg::ST_OK;
        end else begin
            o_res.rect.left           = arlr_pkg::sat_coord(left_w);
            o_res.rect.top            = arlr_pkg::sat_coord(top_w);
            o_res.rect.right          = arlr_pkg::sat_coord(left_w + w_s);
            o_res.rect.bottom         = arlr_pkg::sat_coord(top_w + h_s);
            o_res.clamped_fill_width  = fw;
            o_res.clamped_fill_height = fh;
            o_res.status              = arlr_pkg::ST_OK;
            o_wr_en                   = 1'b1;
        end
    end

endmodule

// ----- design/anchored_rect_layout_resolver_unit.sv -----
// Top level of the anchored rectangle layout resolver.
// An accepted word is held in r_job for the CALC state; its result is loaded into the output
// register when CALC finishes. The two-state sequencer keeps one word in flight and takes no
// new word until CALC is done with the last (anchor read in the accept cycle, write-back as CALC ends).
// Reset: clears control state and sets the screen to 640x480; no table clearing pass.
`timescale 1ns / 1ps

module anchored_rect_layout_resolver_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    arlr_in_if.sink                       i_in,
    arlr_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arlr_pkg::PADDR_W-1:0]  paddr,
    input  logic [arlr_pkg::PDATA_W-1:0]  pwdata,
    output logic [arlr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Two-state sequencer: IDLE takes a word and issues the anchor read,
    // CALC places the element, writes a placed rectangle back and loads the output register.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic                   r_state, n_state;
    arlr_pkg::t_job         r_job;
    arlr_pkg::t_result      r_out;
    logic                   r_out_valid, n_out_valid;

    arlr_pkg::t_cfg         cfg;
    arlr_pkg::t_job         in_job;
    arlr_pkg::t_rect        anchor_rect;
    arlr_pkg::t_result      res;
    logic                   res_wr_en;
    logic                   in_fire;
    logic                   out_fire;
    logic                   calc_done;
    logic [$bits(arlr_pkg::t_rect)-1:0] ram_rd_data;

    arlr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Gather the input word into one struct.
    assign in_job.element_index = i_in.element_index;
    assign in_job.anchor_index  = i_in.anchor_index;
    assign in_job.offset_left   = i_in.offset_left;
    assign in_job.offset_top    = i_in.offset_top;
    assign in_job.rect_width    = i_in.rect_width;
    assign in_job.rect_height   = i_in.rect_height;
    assign in_job.align_flags   = i_in.align_flags;
    assign in_job.is_texture    = i_in.is_texture;
    assign in_job.fill_width    = i_in.fill_width;
    assign in_job.fill_height   = i_in.fill_height;

    // Only one word in flight, so a read never meets a write to the same
    // entry: the write of one word lands before the next word's read.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid & i_in.ready;
    assign out_fire   = o_out.valid & o_out.ready;
    // Finish only when the output register is free or being drained.
    assign calc_done  = (r_state == S_CALC) && (!r_out_valid || o_out.ready);

    arlr_rect_ram #(
        .DEPTH (arlr_pkg::MAX_ELEMENTS),
        .WIDTH ($bits(arlr_pkg::t_rect)),
        .AW    (arlr_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (calc_done & res_wr_en),
        .i_wr_addr (r_job.element_index[arlr_pkg::ADDR_W-1:0]),
        .i_wr_data (res.rect),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_in.anchor_index[arlr_pkg::ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign anchor_rect = arlr_pkg::t_rect'(ram_rd_data);

    arlr_place u_place (
        .i_job    (r_job),
        .i_anchor (anchor_rect),
        .i_cfg    (cfg),
        .o_res    (res),
        .o_wr_en  (res_wr_en)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_CALC;
            end
            S_CALC: begin
                if (calc_done) n_state = S_IDLE;
            end
        endcase
    end

    // Drop valid once the word is taken, unless a new result loads in the same edge.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_fire)  n_out_valid = 1'b0;
        if (calc_done) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the accepted word through the CALC state.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_job <= in_job;
        end
    end

    // Output register: hold the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (calc_done) begin
            r_out <= res;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.out_left            = r_out.rect.left;
    assign o_out.out_top             = r_out.rect.top;
    assign o_out.out_right           = r_out.rect.right;
    assign o_out.out_bottom          = r_out.rect.bottom;
    assign o_out.clamped_fill_width  = r_out.clamped_fill_width;
    assign o_out.clamped_fill_height = r_out.clamped_fill_height;
    assign o_out.status              = r_out.status;

endmodule

// ----- design/arlr_checker.sv -----
// Port-level checker for the layout resolver and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arlr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [arlr_pkg::COORD_W-1:0] i_left,
    input logic signed [arlr_pkg::COORD_W-1:0] i_top,
    input logic signed [arlr_pkg::COORD_W-1:0] i_right,
    input logic signed [arlr_pkg::COORD_W-1:0] i_bottom,
    input logic [arlr_pkg::CFILL_W-1:0]        i_fill_w,
    input logic [arlr_pkg::CFILL_W-1:0]        i_fill_h,
    input logic [arlr_pkg::STATUS_W-1:0]       i_status
);

    logic [4*arlr_pkg::COORD_W+2*arlr_pkg::CFILL_W+arlr_pkg::STATUS_W-1:0] out_word;
    logic out_stall;
    logic in_take;
    logic err_word;
    logic err_payload_zero;
    logic fill_ok;

    assign out_word  = {i_left, i_top, i_right, i_bottom, i_fill_w, i_fill_h, i_status};
    assign out_stall = i_out_valid && !i_out_ready;
    assign in_take   = i_in_valid && i_in_ready;
    assign err_word  = i_out_valid && (i_status != arlr_pkg::ST_OK);
    assign err_payload_zero = (i_left == 0) && (i_top == 0) && (i_right == 0) &&
                              (i_bottom == 0) && (i_fill_w == 0) && (i_fill_h == 0);
    assign fill_ok   = (i_fill_w <= arlr_pkg::FILL_ONE) && (i_fill_h <= arlr_pkg::FILL_ONE);

    // A stalled result word holds.
    `ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(out_word), "stalled result word changed")

    // One word at a time: ready drops right after an accept.
    `ASSERT_NEXT(a_one_in_flight, in_take, !i_in_ready, "input accepted on back-to-back cycles")

    // An error word carries all-zero edges and fills.
    `ASSERT_NOW(a_err_zero, err_word, err_payload_zero, "error word has nonzero payload")

    // Fills never exceed one in unsigned Q1.14.
    `ASSERT_NOW(a_fill_range, i_out_valid, fill_ok, "fill above one")

endmodule

bind anchored_rect_layout_resolver_unit arlr_checker u_arlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left      (o_out.out_left),
    .i_top       (o_out.out_top),
    .i_right     (o_out.out_right),
    .i_bottom    (o_out.out_bottom),
    .i_fill_w    (o_out.clamped_fill_width),
    .i_fill_h    (o_out.clamped_fill_height),
    .i_status    (o_out.status)
);

// ----- tb/tb_anchored_rect_layout_resolver_unit.sv -----
// Self-checking testbench for the anchored rectangle layout resolver.
`timescale 1ns / 1ps

module tb_anchored_rect_layout_resolver_unit;

    // Cycles without any accepted word before the run is declared hung.
    localparam int IDLE_LIMIT  = 3000;
    // Length of the forced receiver hold-off, long enough to back up the input.
    localparam int LONG_HOLD   = 80;
    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE      = 4;
    localparam int PHASES      = 5;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [arlr_pkg::PADDR_W-1:0]  paddr;
    logic [arlr_pkg::PDATA_W-1:0]  pwdata;
    logic [arlr_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    arlr_in_if  in_ch ();
    arlr_out_if out_ch ();

    anchored_rect_layout_resolver_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Element words waiting for the driver, and result words still owed by the block.
    arlr_pkg::t_job    layout_jobs [$];
    arlr_pkg::t_result rects_due [$];

    // Predictor state: our own copy of the screen registers and the rectangle table.
    logic [arlr_pkg::DIM_W-1:0] screen_w_now = arlr_pkg::SCREEN_W_RST;
    logic [arlr_pkg::DIM_W-1:0] screen_h_now = arlr_pkg::SCREEN_H_RST;
    arlr_pkg::t_rect            rect_table [arlr_pkg::MAX_ELEMENTS];

    // Slots that hold a stored rectangle; used only to pick legal anchors.
    bit slot_live [arlr_pkg::MAX_ELEMENTS];

    bit burst_mode         = 1'b0;
    bit long_stall_pending = 1'b0;

    int send_gap;
    int recv_wait;
    int recv_hold_left;
    int idle_cycles;
    int fault_cnt;
    int taken_in;
    int taken_out;
    int screen_words;
    int bad_anchor_words;
    int saturated_words;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a full-width edge to 16-bit signed.
    function automatic logic signed [arlr_pkg::COORD_W-1:0] clip16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[arlr_pkg::COORD_W-1:0];
    endfunction

    // Clamp a signed Q2.14 fraction into zero..one.
    function automatic logic [arlr_pkg::CFILL_W-1:0] limit_fill(
        input logic signed [arlr_pkg::FILL_W-1:0] fv
    );
        int f;
        f = fv;
        if (f < 0) return '0;
        if (f > int'(arlr_pkg::FILL_ONE)) return arlr_pkg::FILL_ONE;
        return f[arlr_pkg::CFILL_W-1:0];
    endfunction

    // Resolve one element against its anchor; store it on success, except for the screen slot.
    function automatic arlr_pkg::t_result place_element(input arlr_pkg::t_job j);
        arlr_pkg::t_result res;
        arlr_pkg::t_rect   a;
        int      elem, anch, w, h;
        int      al, at, ar, ab, l, t;
        res  = '0;
        elem = j.element_index;
        anch = j.anchor_index;
        w    = j.rect_width;
        h    = j.rect_height;

        // Errors: zero edges and fills, store nothing.
        if (elem >= arlr_pkg::MAX_ELEMENTS || anch >= arlr_pkg::MAX_ELEMENTS) begin
            res.status = (elem >= arlr_pkg::MAX_ELEMENTS) ? arlr_pkg::ST_BAD_ELEM
                                                          : arlr_pkg::ST_BAD_ANCH;
            return res;
        end
        if (elem != 0 && anch >= elem) begin
            res.status = arlr_pkg::ST_BAD_ANCH;
            return res;
        end

        res.status = arlr_pkg::ST_OK;
        if (j.is_texture) begin
            res.clamped_fill_width  = limit_fill(j.fill_width);
            res.clamped_fill_height = limit_fill(j.fill_height);
        end

        // The screen slot follows the registers and is never stored.
        if (elem == 0) begin
            res.rect.left   = '0;
            res.rect.top    = '0;
            res.rect.right  = {1'b0, screen_w_now};
            res.rect.bottom = {1'b0, screen_h_now};
            return res;
        end

        if (anch == 0) begin
            al = 0;
            at = 0;
            ar = screen_w_now;
            ab = screen_h_now;
        end else begin
            a  = rect_table[anch];
            al = $signed(a.left);
            at = $signed(a.top);
            ar = $signed(a.right);
            ab = $signed(a.bottom);
        end

        // Apply the flags in bit order; a later flag wins on its axis.
        l = $signed(j.offset_left) + al;
        t = $signed(j.offset_top) + at;
        if (j.align_flags[arlr_pkg::FLG_IN_L])  l = al;
        if (j.align_flags[arlr_pkg::FLG_IN_R])  l = ar - w;
        if (j.align_flags[arlr_pkg::FLG_IN_T])  t = at;
        if (j.align_flags[arlr_pkg::FLG_IN_B])  t = ab - h;
        if (j.align_flags[arlr_pkg::FLG_OUT_L]) l = al - w;
        if (j.align_flags[arlr_pkg::FLG_OUT_R]) l = ar;
        if (j.align_flags[arlr_pkg::FLG_OUT_T]) t = at - h;
        if (j.align_flags[arlr_pkg::FLG_OUT_B]) t = ab;
        // Centering halves truncate toward zero.
        if (j.align_flags[arlr_pkg::FLG_HCTR])  l = al + (ar - al) / 2 - w / 2;
        if (j.align_flags[arlr_pkg::FLG_VCTR])  t = at + (ab - at) / 2 - h / 2;

        // Keep sums at full width; saturate each edge only here.
        res.rect.left   = clip16(l);
        res.rect.top    = clip16(t);
        res.rect.right  = clip16(l + w);
        res.rect.bottom = clip16(t + h);
        rect_table[elem] = res.rect;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one element word; track which slots become legal anchors.
    task automatic queue_element(input int elem, input int anch, input int offl,
                                 input int offt, input int w, input int h,
                                 input int flags, input int tex, input int fw,
                                 input int fh);
        arlr_pkg::t_job j;
        j.element_index = arlr_pkg::IDX_W'(elem);
        j.anchor_index  = arlr_pkg::IDX_W'(anch);
        j.offset_left   = arlr_pkg::COORD_W'(offl);
        j.offset_top    = arlr_pkg::COORD_W'(offt);
        j.rect_width    = arlr_pkg::DIM_W'(w);
        j.rect_height   = arlr_pkg::DIM_W'(h);
        j.align_flags   = arlr_pkg::FLAGS_W'(flags);
        j.is_texture    = tex[0];
        j.fill_width    = arlr_pkg::FILL_W'(fw);
        j.fill_height   = arlr_pkg::FILL_W'(fh);
        layout_jobs.insert(layout_jobs.size(), j);
        if (elem != 0 && anch < elem) slot_live[elem] = 1'b1;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0, 1:    return int'($urandom_range(0, 400)) - 200;
            2:       return int'($signed(16'($urandom)));
            default: return $urandom_range(0, 1) ? 32767 : -32768;
        endcase
    endfunction

    function automatic int rand_size();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(0, 300);
            2:       return $urandom_range(0, 32767);
            default: return $urandom_range(0, 1) ? 32767 : 0;
        endcase
    endfunction

    // Mostly sparse flags so single alignments show up often.
    function automatic int rand_flags();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1 << $urandom_range(0, arlr_pkg::FLAGS_W - 1);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // Bias fills around the clamp limits.
    function automatic int rand_fill();
        case ($urandom_range(0, 3))
            0, 1:    return int'($urandom_range(0, 18000)) - 1000;
            2:       return int'($signed(16'($urandom)));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return int'(arlr_pkg::FILL_ONE);
                    1:       return int'(arlr_pkg::FILL_ONE) + 1;
                    2:       return -1;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    task automatic queue_random(input int elem, input int anch);
        queue_element(elem, anch, rand_coord(), rand_coord(), rand_size(), rand_size(),
                      rand_flags(), $urandom_range(0, 1), rand_fill(), rand_fill());
    endtask

    // Pick a stored slot below elem, favoring the previous one to build chains.
    function automatic int pick_anchor(input int elem);
        int a;
        int k;
        if (elem > 1 && slot_live[elem-1] && $urandom_range(0, 9) < 4) return elem - 1;
        for (k = 0; k < 8; k++) begin
            a = $urandom_range(0, elem - 1);
            if (a == 0 || slot_live[a]) return a;
        end
        return 0;
    endfunction

    // Mostly well-formed layout passes in slot order, with some broken words mixed in.
    task automatic fill_phase(input int count);
        int made;
        int elem;
        int stop_at;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 1)) begin
                    elem = $urandom_range(1, arlr_pkg::MAX_ELEMENTS - 1);
                    queue_random(elem, $urandom_range(elem, arlr_pkg::MAX_ELEMENTS - 1));
                end else begin
                    queue_random(0, $urandom_range(0, arlr_pkg::MAX_ELEMENTS - 1));
                end
                made++;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    queue_random(0, $urandom_range(0, arlr_pkg::MAX_ELEMENTS - 1));
                    made++;
                end
                elem    = $urandom_range(1, 6);
                stop_at = $urandom_range(8, arlr_pkg::MAX_ELEMENTS - 1);
                while (elem <= stop_at && made < count) begin
                    queue_random(elem, pick_anchor(elem));
                    made++;
                    elem += $urandom_range(1, 3);
                end
            end
        end
    endtask

    // Hold the sender until every queued word has gone in and every result came back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (layout_jobs.size() != 0 || in_ch.valid || rects_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [arlr_pkg::REG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= arlr_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= {17'($urandom), arlr_pkg::DIM_W'(value)};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == arlr_pkg::REG_SCREEN_W) screen_w_now = arlr_pkg::DIM_W'(value);
        else screen_h_now = arlr_pkg::DIM_W'(value);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued words, hold until taken, then idle for the drawn gap.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        arlr_pkg::t_job nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the word until the block takes it
        end else if (send_gap > 0) begin
            in_ch.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end else if (layout_jobs.size() != 0) begin
            nxt = layout_jobs.pop_front();
            in_ch.valid         <= 1'b1;
            in_ch.element_index <= nxt.element_index;
            in_ch.anchor_index  <= nxt.anchor_index;
            in_ch.offset_left   <= nxt.offset_left;
            in_ch.offset_top    <= nxt.offset_top;
            in_ch.rect_width    <= nxt.rect_width;
            in_ch.rect_height   <= nxt.rect_height;
            in_ch.align_flags   <= nxt.align_flags;
            in_ch.is_texture    <= nxt.is_texture;
            in_ch.fill_width    <= nxt.fill_width;
            in_ch.fill_height   <= nxt.fill_height;
            send_gap            <= burst_mode ? 0 : $urandom_range(0, 14);
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each result word, plus an occasional long hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            recv_wait      <= 0;
            recv_hold_left <= 0;
        end else if (long_stall_pending) begin
            long_stall_pending = 1'b0;
            recv_hold_left <= LONG_HOLD;
            out_ch.ready   <= 1'b0;
        end else if (recv_hold_left > 0) begin
            recv_hold_left <= recv_hold_left - 1;
            out_ch.ready   <= 1'b0;
        end else if (out_ch.valid && out_ch.ready) begin
            w = burst_mode ? 0 : $urandom_range(0, 14);
            recv_wait    <= w;
            out_ch.ready <= (w == 0);
        end else if (recv_wait > 0) begin
            recv_wait    <= recv_wait - 1;
            out_ch.ready <= (recv_wait == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted element word, check every result word.
    // Input is handled first so a same-edge result still finds its expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        arlr_pkg::t_job    seen;
        arlr_pkg::t_result want;
        arlr_pkg::t_result got;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            seen.element_index = in_ch.element_index;
            seen.anchor_index  = in_ch.anchor_index;
            seen.offset_left   = in_ch.offset_left;
            seen.offset_top    = in_ch.offset_top;
            seen.rect_width    = in_ch.rect_width;
            seen.rect_height   = in_ch.rect_height;
            seen.align_flags   = in_ch.align_flags;
            seen.is_texture    = in_ch.is_texture;
            seen.fill_width    = in_ch.fill_width;
            seen.fill_height   = in_ch.fill_height;
            want = place_element(seen);
            rects_due.insert(rects_due.size(), want);
            taken_in++;
            if (seen.element_index == 0) screen_words++;
            if (want.status == arlr_pkg::ST_BAD_ANCH) bad_anchor_words++;
            if (want.rect.left == 16'sh7FFF || want.rect.left == 16'sh8000 ||
                want.rect.top == 16'sh7FFF || want.rect.top == 16'sh8000 ||
                want.rect.right == 16'sh7FFF || want.rect.bottom == 16'sh7FFF)
                saturated_words++;
        end

        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.rect.left           = out_ch.out_left;
            got.rect.top            = out_ch.out_top;
            got.rect.right          = out_ch.out_right;
            got.rect.bottom         = out_ch.out_bottom;
            got.clamped_fill_width  = out_ch.clamped_fill_width;
            got.clamped_fill_height = out_ch.clamped_fill_height;
            got.status              = out_ch.status;
            taken_out++;
            if (rects_due.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("ERROR: result word %0d arrived with nothing outstanding",
                             taken_out);
            end else begin
                want = rects_due.pop_front();
                if (got.rect.left !== want.rect.left || got.rect.top !== want.rect.top ||
                    got.rect.right !== want.rect.right ||
                    got.rect.bottom !== want.rect.bottom ||
                    got.clamped_fill_width !== want.clamped_fill_width ||
                    got.clamped_fill_height !== want.clamped_fill_height ||
                    got.status !== want.status) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("ERROR: result word %0d mismatch", taken_out);
                        $display("  exp l=%0d t=%0d r=%0d b=%0d fw=%0d fh=%0d st=%0d",
                                 want.rect.left, want.rect.top, want.rect.right,
                                 want.rect.bottom, want.clamped_fill_width,
                                 want.clamped_fill_height, want.status);
                        $display("  got l=%0d t=%0d r=%0d b=%0d fw=%0d fh=%0d st=%0d",
                                 got.rect.left, got.rect.top, got.rect.right,
                                 got.rect.bottom, got.clamped_fill_width,
                                 got.clamped_fill_height, got.status);
                    end
                end
            end
        end
    end

    // Watchdog: drop the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, rects_due.size());
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed words under reset settings, then random phases,
    // each under its own screen size and written only while the block is idle.
    // ------------------------------------------------------------------
    initial begin
        int phase_w [PHASES];
        int phase_h [PHASES];
        int phase_n [PHASES];

        // Drive every block input to a known value from time zero.
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.element_index = '0;
        in_ch.anchor_index  = '0;
        in_ch.offset_left   = '0;
        in_ch.offset_top    = '0;
        in_ch.rect_width    = '0;
        in_ch.rect_height   = '0;
        in_ch.align_flags   = '0;
        in_ch.is_texture    = 1'b0;
        in_ch.fill_width    = '0;
        in_ch.fill_height   = '0;
        out_ch.ready        = 1'b0;
        idle_cycles         = 0;
        fault_cnt           = 0;
        taken_in            = 0;
        taken_out           = 0;
        screen_words        = 0;
        bad_anchor_words    = 0;
        saturated_words     = 0;
        foreach (rect_table[i]) rect_table[i] = '0;
        foreach (slot_live[i]) slot_live[i] = 1'b0;

        // Extremes first, then random sizes, one setting back at the reset values.
        phase_w = '{0, 32767, $urandom_range(0, 32767), $urandom_range(1, 32767), 640};
        phase_h = '{0, 32767, $urandom_range(0, 32767), 32767, 480};
        phase_n = '{100, 300, 350, 400, 400};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Screen slot: anchor and sizes ignored, fills clamped at both ends.
        queue_element(0, 37, 1234, -99, 77, 88, 1023, 1, -32768, 32767);
        queue_element(0, 63, -1, -1, 32767, 32767, 1023, 0, 5000, 6000);
        // Plain offset placement, fills at and just above one.
        queue_element(1, 0, 10, 20, 100, 50, 0, 1, 16384, 16385);
        // Each alignment flag alone, alternating screen and element 1 as anchor.
        for (int b = 0; b < arlr_pkg::FLAGS_W; b++)
            queue_element(2 + b, b % 2, 33, -44, 101, 51, 1 << b, b % 2, 8192, -1);
        // All flags at once: centering overrides the rest on both axes.
        queue_element(12, 11, 5, 5, 77, 33, 1023, 1, 0, 1);
        // Saturate high: offsets and sizes at their maximum.
        queue_element(13, 0, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
        // Saturate low: chain two placements far to the negative side.
        queue_element(14, 0, -32768, -32768, 0, 0, 0, 1, 32767, -32768);
        queue_element(15, 14, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
        // Center on a saturated anchor with odd sizes.
        queue_element(16, 13, 0, 0, 32767, 32765, 768, 1, 100, 200);
        // Bad anchor: equal to the element, then above it.
        queue_element(17, 17, 1, 2, 3, 4, 1, 1, 16384, 16384);
        queue_element(5, 63, -5, -6, 7, 8, 512, 1, 1000, 1000);
        // Highest slot anchored to a saturated-low rectangle.
        queue_element(63, 15, 100, -100, 1, 2, 160, 1, 16383, 16383);
        queue_element(1, 0, -7, 9, 0, 0, 0, 1, -1, -16384);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(arlr_pkg::REG_SCREEN_W, phase_w[p]);
            write_reg(arlr_pkg::REG_SCREEN_H, phase_h[p]);
            // Run one phase with no idling on either side.
            burst_mode = (p == 3);
            fill_phase(phase_n[p]);
            // Starve the output while the input keeps offering, to fill the block.
            if (p == 1 || p == 3) long_stall_pending = 1'b1;
        end
        wait_drained();

        $display("summary: %0d element words in, %0d results checked, %0d screen slot",
                 taken_in, taken_out, screen_words);
        $display("summary: %0d bad anchors, %0d saturated, %0d screen settings, %0d faults",
                 bad_anchor_words, saturated_words, PHASES + 1, fault_cnt);
        if (fault_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
